// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SSID_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SSID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ssid_pkg.sv =====
// shared types and constants for the sorted set block
`timescale 1ns / 1ps

package ssid_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_DELETE   = 2'd1,
        MODE_DUMP_ASC = 2'd2,
        MODE_DUMP_DSC = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_DELETED   = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_EMPTY     = 3'd4,
        STAT_FULL      = 3'd5,
        STAT_ENTRY     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    // per-cell flags handed to the neighbors
    typedef struct packed {
        logic valid;
        logic lt;
        logic match;
    } cell_flags_t;

    // summary of the whole row
    typedef struct packed {
        logic found;
        logic full;
    } chain_stat_t;

endpackage

// ===== hw/rtl/ssid_cell.sv =====
// one cell of the sorted row: holds an entry and its valid bit
`timescale 1ns / 1ps

module ssid_cell
    import ssid_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_op_t                   op,
    input  logic signed [VALUE_W-1:0]  val,
    input  logic                       found,
    input  logic signed [VALUE_W-1:0]  left_entry,
    input  cell_flags_t                left_flags,
    input  logic signed [VALUE_W-1:0]  right_entry,
    input  cell_flags_t                right_flags,
    output logic signed [VALUE_W-1:0]  entry,
    output cell_flags_t                flags
);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      valid_reg;
    logic                      valid_next;

    // local compare against the requested value
    always_comb
    begin
        flags.valid = valid_reg;
        flags.lt    = valid_reg && (entry_reg < val);
        flags.match = valid_reg && (entry_reg == val);
    end

    assign entry = entry_reg;

    // shift right on insert, shift left on delete
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        case (op)
            OP_INSERT:
            begin
                if (!flags.lt)
                begin
                    valid_next = left_flags.valid;
                    entry_next = left_flags.lt ? val : left_entry;
                end
            end
            OP_DELETE:
            begin
                if (found && valid_reg && !flags.lt)
                begin
                    valid_next = right_flags.valid;
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hw/rtl/ssid_chain.sv =====
// row of compare-and-shift cells holding the sorted entries
`timescale 1ns / 1ps

module ssid_chain
    import ssid_pkg::*;
`include "assert_macros.svh"
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_op_t                   op,
    input  logic signed [VALUE_W-1:0]  val,
    output logic signed [VALUE_W-1:0]  entries [CAPACITY],
    output chain_stat_t                stat
);

    cell_flags_t               flags       [CAPACITY];
    logic signed [VALUE_W-1:0] left_entry  [CAPACITY];
    cell_flags_t               left_flags  [CAPACITY];
    logic signed [VALUE_W-1:0] right_entry [CAPACITY];
    cell_flags_t               right_flags [CAPACITY];
    logic                      found;

    // any cell holding the value
    always_comb
    begin
        found = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            found = found | flags[i].match;
        end
    end

    assign stat.found = found;
    assign stat.full  = flags[CAPACITY-1].valid;

    // cells and neighbor wiring
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            assign left_entry[g] = '0;
            assign left_flags[g] = '{valid: 1'b1, lt: 1'b1, match: 1'b0};
        end
        else
        begin : g_body
            assign left_entry[g] = entries[g-1];
            assign left_flags[g] = flags[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_entry[g] = '0;
            assign right_flags[g] = '{valid: 1'b0, lt: 1'b0, match: 1'b0};
        end
        else
        begin : g_inner
            assign right_entry[g] = entries[g+1];
            assign right_flags[g] = flags[g+1];
        end

        ssid_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .val         (val),
            .found       (found),
            .left_entry  (left_entry[g]),
            .left_flags  (left_flags[g]),
            .right_entry (right_entry[g]),
            .right_flags (right_flags[g]),
            .entry       (entries[g]),
            .flags       (flags[g])
        );
    end

    // valid cells form a prefix and hold strictly ascending values
    for (genvar a = 0; a < CAPACITY - 1; a++)
    begin : g_chk
        `SSID_ASSERT_ALWAYS(a_prefix, !flags[a+1].valid || flags[a].valid, "valid bits not a prefix")
        `SSID_ASSERT_ALWAYS(a_order, !flags[a+1].valid || (entries[a] < entries[a+1]), "entries out of order")
    end

endmodule

// ===== hw/rtl/sorted_set_insert_delete.sv =====
// Sorted set of distinct signed values kept in a row of compare-and-shift cells.
// Insert and delete: the result enters the output register as the input is taken.
// Dump: count entries, one per cycle unless the sink stalls (one result if empty).
// The next input is taken once the previous item's last result is loaded; a result
// still waiting for the sink holds off the input until the sink takes it.
// Reset clears the entry count, the cell valid bits and the output valid.
`timescale 1ns / 1ps

module sorted_set_insert_delete
    import ssid_pkg::*;
`include "assert_macros.svh"
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode[1:0], value[33:2], zero pad[39:34]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[2:0], entry_value[34:3], entry_count[39:35]
    output logic        m_tlast
);

    mode_t                     in_mode;
    logic signed [VALUE_W-1:0] in_value;
    logic                      accept;
    logic                      out_free;

    state_t                    state_reg;
    state_t                    state_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          idx_next;
    logic                      desc_reg;
    logic                      desc_next;

    cell_op_t                  op;
    chain_stat_t               stat;
    logic signed [VALUE_W-1:0] entries [CAPACITY];
    logic [IDX_W-1:0]          rd_idx;
    logic                      dump_last;

    logic                      load;
    status_t                   ld_status;
    logic signed [VALUE_W-1:0] ld_value;
    logic                      ld_last;

    logic                      out_valid_reg;
    status_t                   out_status_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [COUNT_W-1:0]        out_count_reg;
    logic                      out_last_reg;

    // input unpacking and handshake
    assign in_mode  = mode_t'(s_tdata[1:0]);
    assign in_value = s_tdata[33:2];
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // cell row
    ssid_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .val     (in_value),
        .entries (entries),
        .stat    (stat)
    );

    // dump read position
    assign rd_idx    = desc_reg ? IDX_W'(count_reg - CNT_W'(1) - CNT_W'(idx_reg)) : idx_reg;
    assign dump_last = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_mode == MODE_DUMP_ASC || in_mode == MODE_DUMP_DSC)
                    && count_reg != '0)
                begin
                    state_next = S_DUMP;
                end
            end
            S_DUMP:
            begin
                if (out_free && dump_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // cell operation, count, dump index and result load
    always_comb
    begin
        op         = OP_HOLD;
        count_next = count_reg;
        idx_next   = idx_reg;
        desc_next  = desc_reg;
        load       = 1'b0;
        ld_status  = STAT_EMPTY;
        ld_value   = in_value;
        ld_last    = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_mode)
                        MODE_INSERT:
                        begin
                            load = 1'b1;
                            if (stat.found)
                            begin
                                ld_status = STAT_DUPLICATE;
                            end
                            else if (stat.full)
                            begin
                                ld_status = STAT_FULL;
                            end
                            else
                            begin
                                ld_status  = STAT_INSERTED;
                                op         = OP_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_DELETE:
                        begin
                            load = 1'b1;
                            if (count_reg == '0)
                            begin
                                ld_status = STAT_EMPTY;
                            end
                            else if (!stat.found)
                            begin
                                ld_status = STAT_NOT_FOUND;
                            end
                            else
                            begin
                                ld_status  = STAT_DELETED;
                                op         = OP_DELETE;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            idx_next  = '0;
                            desc_next = (in_mode == MODE_DUMP_DSC);
                            if (count_reg == '0)
                            begin
                                load      = 1'b1;
                                ld_status = STAT_EMPTY;
                                ld_value  = '0;
                            end
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    ld_status = STAT_ENTRY;
                    ld_value  = entries[rd_idx];
                    ld_last   = dump_last;
                    idx_next  = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            desc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            desc_reg  <= desc_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_status_reg <= ld_status;
            out_value_reg  <= ld_value;
            out_count_reg  <= COUNT_W'(count_next);
            out_last_reg   <= ld_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_value_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    `SSID_ASSERT_ALWAYS(a_count_max, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `SSID_ASSERT_ALWAYS(a_busy_no_take, state_reg != S_DUMP || !s_tready, "input taken during dump")
    `SSID_ASSERT_NEXT(a_ins_count, op == OP_INSERT, count_reg == $past(count_reg) + CNT_W'(1), "insert count")
    `SSID_ASSERT_NEXT(a_del_count, op == OP_DELETE, count_reg == $past(count_reg) - CNT_W'(1), "delete count")
    `SSID_ASSERT_ALWAYS(a_dump_nonempty, state_reg != S_DUMP || count_reg != '0, "dump of empty set")

endmodule

// ===== bench/sorted_set_insert_delete_checker.sv =====
// checker for the sorted set block: tracks the set, predicts each result, compares transfers
`timescale 1ns / 1ps

module sorted_set_insert_delete_checker
    import ssid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // mode[1:0], value[33:2], zero pad[39:34]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // status[2:0], entry_value[34:3], entry_count[39:35]
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        status_t               status;
        logic [VALUE_W-1:0]    value;
        logic [COUNT_W-1:0]    count;
        logic                  last;
    } set_result_t;

    // shadow copy of the set, kept ascending
    logic signed [VALUE_W-1:0] shadow_entries [CAPACITY];
    int                        shadow_count;
    set_result_t               awaited_results [$];

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        shadow_count = 0;
    end

    // queue one expected result, count taken after the set update
    function automatic void await_result(status_t st, logic [VALUE_W-1:0] val, logic lst);
        set_result_t r;
        r.status = st;
        r.value  = val;
        r.count  = shadow_count[COUNT_W-1:0];
        r.last   = lst;
        awaited_results.push_back(r);
    endfunction

    // apply one request to the shadow set and queue what it must produce
    function automatic void predict_set_op(mode_t op, logic signed [VALUE_W-1:0] val);
        int pos;
        int k;
        case (op)
            MODE_INSERT:
            begin
                pos = 0;
                while (pos < shadow_count && shadow_entries[pos] < val)
                    pos++;
                // duplicate check wins over the full check
                if (pos < shadow_count && shadow_entries[pos] == val)
                    await_result(STAT_DUPLICATE, val, 1'b1);
                else if (shadow_count >= CAPACITY)
                    await_result(STAT_FULL, val, 1'b1);
                else
                begin
                    for (k = shadow_count; k > pos; k--)
                        shadow_entries[k] = shadow_entries[k-1];
                    shadow_entries[pos] = val;
                    shadow_count++;
                    await_result(STAT_INSERTED, val, 1'b1);
                end
            end
            MODE_DELETE:
            begin
                pos = 0;
                while (pos < shadow_count && shadow_entries[pos] != val)
                    pos++;
                if (shadow_count == 0)
                    await_result(STAT_EMPTY, val, 1'b1);
                else if (pos >= shadow_count)
                    await_result(STAT_NOT_FOUND, val, 1'b1);
                else
                begin
                    for (k = pos; k + 1 < shadow_count; k++)
                        shadow_entries[k] = shadow_entries[k+1];
                    shadow_count--;
                    await_result(STAT_DELETED, val, 1'b1);
                end
            end
            default:
            begin
                // dumps: one entry per result, or a single empty status
                if (shadow_count == 0)
                    await_result(STAT_EMPTY, '0, 1'b1);
                else
                    for (k = 0; k < shadow_count; k++)
                        await_result(STAT_ENTRY,
                            shadow_entries[(op == MODE_DUMP_ASC) ? k : shadow_count - 1 - k],
                            k == shadow_count - 1);
            end
        endcase
    endfunction

    // sample mid-cycle: inputs change only at the rising edge, so a transfer
    // seen here is the one taken at the next edge
    always @(negedge clk)
    begin : watch_transfers
        set_result_t got;
        set_result_t exp;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = status_t'(m_tdata[2:0]);
                got.value  = m_tdata[34:3];
                got.count  = m_tdata[39:35];
                got.last   = m_tlast;
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: status %0d value %0d count %0d last %0d",
                                 got.status, $signed(got.value), got.count, got.last);
                end
                else
                begin
                    exp = awaited_results.pop_front();
                    if (got.status != exp.status || got.value != exp.value ||
                        got.count != exp.count || got.last != exp.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: exp status %0d value %0d count %0d last %0d, got status %0d value %0d count %0d last %0d",
                                     exp.status, $signed(exp.value), exp.count, exp.last,
                                     got.status, $signed(got.value), got.count, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_set_op(mode_t'(s_tdata[1:0]), s_tdata[33:2]);
            pending = awaited_results.size();
        end
    end

endmodule

// ===== bench/sorted_set_insert_delete_tb.sv =====
// testbench top for the sorted set block: request stimulus, sink stalls, watchdog and verdict
`timescale 1ns / 1ps

module sorted_set_insert_delete_tb;
    import ssid_pkg::*;

    localparam int ITEM_TARGET    = 210;
    localparam int CALM_ITEMS     = 30;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int POOL_SIZE      = 24;

    localparam logic [31:0] VAL_MAX  = 32'h7fff_ffff;
    localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [31:0] VAL_ZERO = 32'h0000_0000;
    localparam logic [31:0] VAL_NEG1 = 32'hffff_ffff;
    localparam logic [31:0] VAL_ONE  = 32'h0000_0001;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [39:0] m_tdata;
    logic        m_tlast;

    int          fail_count;
    int          pending;
    int          items_sent = 0;
    bit          calm       = 1'b0;
    int          ready_run  = 0;
    int          idle_cycles = 0;
    logic [31:0] value_pool [POOL_SIZE];

    always #10 clk = ~clk;

    sorted_set_insert_delete dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sorted_set_insert_delete_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // sink stalls in random bursts, none once the run is calm
    always @(posedge clk)
    begin
        if (ready_run > 0)
            ready_run <= ready_run - 1;
        else if (!calm && m_tready && $urandom_range(0, 3) == 0)
        begin
            m_tready  <= 1'b0;
            ready_run <= $urandom_range(0, 11);
        end
        else
        begin
            m_tready  <= 1'b1;
            ready_run <= $urandom_range(0, 20);
        end
    end

    // watchdog on cycles without any transfer
    always @(negedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // one request transfer, with an optional idle burst ahead of it
    task automatic send_item(input mode_t op, input logic [31:0] val);
        calm = (items_sent >= ITEM_TARGET - CALM_ITEMS);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, val, op};
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    // fresh set of distinct values, some of them extremes
    task automatic refill_pool();
        int i;
        int j;
        bit clash;
        for (i = 0; i < POOL_SIZE; i++)
        begin
            case ($urandom_range(0, 11))
                0:       value_pool[i] = VAL_MAX;
                1:       value_pool[i] = VAL_MIN;
                2:       value_pool[i] = VAL_ZERO;
                3:       value_pool[i] = VAL_NEG1;
                default: value_pool[i] = $urandom;
            endcase
            do
            begin
                clash = 1'b0;
                for (j = 0; j < i; j++)
                    if (value_pool[j] == value_pool[i])
                        clash = 1'b1;
                if (clash)
                    value_pool[i] = $urandom;
            end
            while (clash);
        end
    endtask

    initial
    begin : stimulus
        int i;
        int phase_kind;
        int phase_len;
        int pick;
        logic [31:0] val;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty set, extremes, duplicate, missing value, both dumps
        send_item(MODE_DUMP_ASC, VAL_NEG1);
        send_item(MODE_DUMP_DSC, VAL_MAX);
        send_item(MODE_DELETE, 32'd5);
        send_item(MODE_INSERT, VAL_ZERO);
        send_item(MODE_INSERT, VAL_MAX);
        send_item(MODE_INSERT, VAL_MIN);
        send_item(MODE_INSERT, VAL_NEG1);
        send_item(MODE_INSERT, VAL_ONE);
        send_item(MODE_INSERT, VAL_MAX);
        send_item(MODE_DELETE, 32'd7);
        send_item(MODE_DUMP_ASC, VAL_ZERO);
        send_item(MODE_DUMP_DSC, VAL_MIN);
        send_item(MODE_DELETE, VAL_MIN);
        send_item(MODE_DELETE, VAL_MAX);
        send_item(MODE_DELETE, VAL_ZERO);
        send_item(MODE_DELETE, VAL_ONE);
        send_item(MODE_DELETE, VAL_NEG1);
        send_item(MODE_DELETE, VAL_NEG1);

        // fill from empty: the set is full after sixteen, the rest are refused,
        // then a duplicate into the full set
        refill_pool();
        for (i = 0; i < POOL_SIZE; i++)
            send_item(MODE_INSERT, value_pool[i]);
        send_item(MODE_INSERT, value_pool[3]);
        send_item(MODE_DUMP_ASC, $urandom);
        send_item(MODE_DUMP_DSC, $urandom);

        // random phases: insert-heavy, delete-heavy or mixed, values mostly from the pool
        while (items_sent < ITEM_TARGET)
        begin
            phase_kind = $urandom_range(0, 2);
            phase_len  = $urandom_range(8, 30);
            if ($urandom_range(0, 1) == 0)
                refill_pool();
            for (i = 0; i < phase_len && items_sent < ITEM_TARGET; i++)
            begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0)
                    val = $urandom;
                else
                    val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
                if (pick < ((phase_kind == 0) ? 60 : (phase_kind == 1) ? 20 : 40))
                    send_item(MODE_INSERT, val);
                else if (pick < ((phase_kind == 2) ? 75 : 85))
                    send_item(MODE_DELETE, val);
                else if (pick[0])
                    send_item(MODE_DUMP_ASC, $urandom);
                else
                    send_item(MODE_DUMP_DSC, $urandom);
            end
        end
        s_tvalid <= 1'b0;

        // drain, then keep watching for anything stray before the verdict
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sorted_set_insert_delete.f =====
+incdir+hw/rtl
hw/rtl/ssid_pkg.sv
hw/rtl/ssid_cell.sv
hw/rtl/ssid_chain.sv
hw/rtl/sorted_set_insert_delete.sv
bench/sorted_set_insert_delete_checker.sv
bench/sorted_set_insert_delete_tb.sv
